### rtl/bgpl_pkg.sv
// ----------------------------------------------------------------------------
// bgpl_pkg
// Widths, reset values, register indexes and helpers of the ground point
// locator.
// ----------------------------------------------------------------------------
package bgpl_pkg;

	localparam int BOX_W   = 16;
	localparam int COORD_W = 24;
	localparam int WORLD_W = 32;
	localparam int CFG_IW  = 3;
	localparam int CFG_DW  = 64;
	localparam int H_W     = 32;
	localparam int OFS_W   = 17;
	localparam int UNIT_W  = 17;

	// divider (every instance): divisor/remainder width and quotient bits (one per stage)
	localparam int DIV_DW = 60;
	localparam int DIV_QW = 31;
	// square root: radicand width and root bits (one per stage)
	localparam int SQ_W  = 62;
	localparam int SQ_RW = 31;

	localparam int PIPE_DEPTH = 13 + 3 * DIV_QW + SQ_RW;

	localparam logic [31:0] CAL_SIZE_RST = 32'h0438_0780;
	localparam logic [31:0] DET_SIZE_RST = 32'h0438_0780;
	localparam logic [63:0] H_A_RST      = 64'h0000_0000_0100_0000;
	localparam logic [63:0] H_B_RST      = 64'h0;
	localparam logic [63:0] H_C_RST      = 64'h0000_0000_0100_0000;
	localparam logic [63:0] H_D_RST      = 64'h0;
	localparam logic [31:0] H_E_RST      = 32'h0100_0000;

	localparam logic [OFS_W-1:0] OFS_LOW     = 17'd32768;
	localparam logic [OFS_W-1:0] OFS_HIGH    = 17'd98304;
	localparam logic [17:0]      OFS_BASE    = 18'd163840;
	localparam logic [15:0]      ASPECT_HALF = 16'd32768;

	typedef enum logic [CFG_IW-1:0] {
		REG_CAL_SIZE = 3'd0,
		REG_DET_SIZE = 3'd1,
		REG_H_A      = 3'd2,
		REG_H_B      = 3'd3,
		REG_H_C      = 3'd4,
		REG_H_D      = 3'd5,
		REG_H_E      = 3'd6
	} cfg_reg_t;

	function automatic logic signed [WORLD_W-1:0] sat32(input logic signed [33:0] v);
		logic signed [WORLD_W-1:0] r;
		if (v > 34'sd2147483647) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -34'sd2147483648) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[WORLD_W-1:0];
		end
		return r;
	endfunction

endpackage

### rtl/bgpl_if.sv
// ----------------------------------------------------------------------------
// bgpl interfaces
// Valid/ready channels of the ground point locator: boxes, results, config.
// ----------------------------------------------------------------------------
interface bgpl_box_if import bgpl_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [BOX_W-1:0] box_min_x;
	logic [BOX_W-1:0] box_min_y;
	logic [BOX_W-1:0] box_max_x;
	logic [BOX_W-1:0] box_max_y;

	modport source(output valid, box_min_x, box_min_y, box_max_x, box_max_y,
		input ready);
	modport sink(input valid, box_min_x, box_min_y, box_max_x, box_max_y,
		output ready);
endinterface

interface bgpl_res_if import bgpl_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [WORLD_W-1:0] world_x;
	logic signed [WORLD_W-1:0] world_y;
	logic                      invalid;

	modport source(output valid, world_x, world_y, invalid, input ready);
	modport sink(input valid, world_x, world_y, invalid, output ready);
endinterface

interface bgpl_cfg_if import bgpl_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CFG_IW-1:0] index;
	logic [CFG_DW-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

### rtl/bgpl_div.sv
// ----------------------------------------------------------------------------
// bgpl_div
// Pipelined restoring divider, one quotient bit per stage. The caller gives
// the starting remainder (below the divisor) and the numerator bits to shift.
// ----------------------------------------------------------------------------
module bgpl_div import bgpl_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [DIV_DW-1:0] divisor,
	input  logic [DIV_DW-1:0] rem_in,
	input  logic [DIV_QW-1:0] low_in,
	output logic [DIV_QW-1:0] quot
);

	logic [DIV_DW-1:0] dvs_q  [DIV_QW];
	logic [DIV_DW-1:0] rem_q  [DIV_QW];
	logic [DIV_QW-1:0] bits_q [DIV_QW];

	logic [DIV_DW-1:0] dvs_src  [DIV_QW];
	logic [DIV_DW-1:0] rem_src  [DIV_QW];
	logic [DIV_QW-1:0] bits_src [DIV_QW];

	for (genvar k = 0; k < DIV_QW; k++) begin : g_stage
		logic [DIV_DW:0] trial;
		logic            take;

		if (k == 0) begin : g_first
			assign dvs_src[k]  = divisor;
			assign rem_src[k]  = rem_in;
			assign bits_src[k] = low_in;
		end else begin : g_next
			assign dvs_src[k]  = dvs_q[k-1];
			assign rem_src[k]  = rem_q[k-1];
			assign bits_src[k] = bits_q[k-1];
		end

		// numerator bits leave at the top, quotient bits enter at the bottom
		assign trial = {rem_src[k], bits_src[k][DIV_QW-1]};
		assign take  = trial >= {1'b0, dvs_src[k]};

		always_ff @(posedge clk) begin
			if (en) begin
				dvs_q[k]  <= dvs_src[k];
				rem_q[k]  <= take ? DIV_DW'(trial - {1'b0, dvs_src[k]}) : trial[DIV_DW-1:0];
				bits_q[k] <= {bits_src[k][DIV_QW-2:0], take};
			end
		end
	end

	assign quot = bits_q[DIV_QW-1];

endmodule

### rtl/bgpl_sqrt.sv
// ----------------------------------------------------------------------------
// bgpl_sqrt
// Pipelined integer square root (floor), one root bit per stage.
// ----------------------------------------------------------------------------
module bgpl_sqrt import bgpl_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  logic [SQ_W-1:0]  radicand,
	output logic [SQ_RW-1:0] root
);

	logic [SQ_W-1:0] x_q [SQ_RW];
	logic [SQ_W-1:0] r_q [SQ_RW];

	logic [SQ_W-1:0] x_src [SQ_RW];
	logic [SQ_W-1:0] r_src [SQ_RW];

	for (genvar k = 0; k < SQ_RW; k++) begin : g_stage
		localparam logic [SQ_W-1:0] BIT_K = SQ_W'(1) << (2 * (SQ_RW - 1 - k));
		logic [SQ_W-1:0] trial;
		logic            take;

		if (k == 0) begin : g_first
			assign x_src[k] = radicand;
			assign r_src[k] = '0;
		end else begin : g_next
			assign x_src[k] = x_q[k-1];
			assign r_src[k] = r_q[k-1];
		end

		assign trial = r_src[k] + BIT_K;
		assign take  = x_src[k] >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				x_q[k] <= take ? x_src[k] - trial : x_src[k];
				r_q[k] <= take ? (r_src[k] >> 1) + BIT_K : r_src[k] >> 1;
			end
		end
	end

	assign root = r_q[SQ_RW-1][SQ_RW-1:0];

endmodule

### rtl/bbox_ground_point_locator.sv
// ----------------------------------------------------------------------------
// bbox_ground_point_locator
// Scales a detection box to calibrated pixels, projects its bottom middle
// through the homography and steps along the ground direction by an
// aspect-dependent offset.
// Pipeline: three 31-stage divider passes, one 31-stage square root, 13
//   datapath registers and the output register.
// Throughput: one box per cycle while the skid register is empty; a stalled
//   output parks one result in the skid register and input ready drops the cycle after.
// Reset: clears all valid bits and loads the default calibration; no
//   clearing pass.
// ----------------------------------------------------------------------------
module bbox_ground_point_locator import bgpl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	bgpl_cfg_if.sink  cfg,
	bgpl_box_if.sink  box,
	bgpl_res_if.source result
);

	typedef struct packed {
		logic [COORD_W-1:0] wid_mag;
		logic [COORD_W-1:0] hgt_mag;
		logic               hzero;
		logic               neg;
	} asp_t;

	typedef struct packed {
		logic       bad;
		logic [3:0] neg;
		logic [3:0] sat;
		logic       asp_neg;
		logic       asp_big;
	} sideb_t;

	typedef struct packed {
		logic signed [WORLD_W-1:0] p1x;
		logic signed [WORLD_W-1:0] p1y;
		logic [OFS_W-1:0]          ofs;
		logic                      sx;
		logic                      sy;
		logic                      bad;
	} sided_t;

	typedef struct packed {
		sided_t      base;
		logic [29:0] ax;
		logic [29:0] ay;
	} sidec_t;

	typedef struct packed {
		logic signed [WORLD_W-1:0] wx;
		logic signed [WORLD_W-1:0] wy;
		logic                      inv;
	} res_t;

	// ---------------- configuration ----------------
	logic [31:0] cal_size_q;
	logic [31:0] det_size_q;
	logic [63:0] h_a_q;
	logic [63:0] h_b_q;
	logic [63:0] h_c_q;
	logic [63:0] h_d_q;
	logic [31:0] h_e_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_size_q <= CAL_SIZE_RST;
			det_size_q <= DET_SIZE_RST;
			h_a_q      <= H_A_RST;
			h_b_q      <= H_B_RST;
			h_c_q      <= H_C_RST;
			h_d_q      <= H_D_RST;
			h_e_q      <= H_E_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_CAL_SIZE: cal_size_q <= cfg.data[31:0];
				REG_DET_SIZE: det_size_q <= cfg.data[31:0];
				REG_H_A:      h_a_q      <= cfg.data;
				REG_H_B:      h_b_q      <= cfg.data;
				REG_H_C:      h_c_q      <= cfg.data;
				REG_H_D:      h_d_q      <= cfg.data;
				REG_H_E:      h_e_q      <= cfg.data[31:0];
				default: ;
			endcase
		end
	end

	logic [15:0] cw, ch, dw, dh;
	assign cw = cal_size_q[15:0];
	assign ch = cal_size_q[31:16];
	assign dw = det_size_q[15:0];
	assign dh = det_size_q[31:16];

	logic signed [H_W-1:0] h0, h1, h2, h3, h4, h5, h6, h7, h8;
	assign h0 = h_a_q[31:0];
	assign h1 = h_a_q[63:32];
	assign h2 = h_b_q[31:0];
	assign h3 = h_b_q[63:32];
	assign h4 = h_c_q[31:0];
	assign h5 = h_c_q[63:32];
	assign h6 = h_d_q[31:0];
	assign h7 = h_d_q[63:32];
	assign h8 = h_e_q;

	// ---------------- flow control ----------------
	logic                  en;
	logic                  take_in;
	logic                  push;
	logic [PIPE_DEPTH-1:0] stage_vld_q;
	logic                  out_vld_q;
	logic                  sp_vld_q;
	res_t                  out_q;
	res_t                  sp_q;
	res_t                  res_nx;

	assign en        = !sp_vld_q;
	assign box.ready = en;
	assign take_in   = box.valid && en;
	assign push      = en && stage_vld_q[PIPE_DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
		end else if (en) begin
			stage_vld_q <= {stage_vld_q[PIPE_DEPTH-2:0], take_in};
		end
	end

	// ---------------- s1: corner times calibrated size ----------------
	logic [31:0] prod_s1 [4];

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1[0] <= box.box_min_x * cw;
			prod_s1[1] <= box.box_min_y * ch;
			prod_s1[2] <= box.box_max_x * cw;
			prod_s1[3] <= box.box_max_y * ch;
		end
	end

	// ---------------- scale dividers ----------------
	logic [35:0]        num_a   [4];
	logic [15:0]        scl_dvs [4];
	logic [3:0]         sat_a;
	logic [DIV_QW-1:0]  quot_a  [4];
	logic [3:0]         sat_a_q [DIV_QW];
	logic [COORD_W-1:0] corner_nx [4];

	for (genvar i = 0; i < 4; i++) begin : g_scale
		assign num_a[i]   = {prod_s1[i], 4'b0};
		assign scl_dvs[i] = (i % 2 == 0) ? dw : dh;
		// quotient above 24 bits saturates
		assign sat_a[i]   = {4'b0, num_a[i][35:24]} >= scl_dvs[i];

		bgpl_div u_div (
			.clk     (clk),
			.en      (en),
			.divisor (DIV_DW'(scl_dvs[i])),
			.rem_in  (DIV_DW'(num_a[i][35:24])),
			.low_in  ({num_a[i][23:0], 7'b0}),
			.quot    (quot_a[i])
		);

		assign corner_nx[i] = (scl_dvs[i] == '0) ? '0 :
			sat_a_q[DIV_QW-1][i] ? '1 : quot_a[i][DIV_QW-1 -: COORD_W];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sat_a_q[0] <= sat_a;
			for (int k = 1; k < DIV_QW; k++) sat_a_q[k] <= sat_a_q[k-1];
		end
	end

	// ---------------- s2: scaled corners ----------------
	logic [COORD_W-1:0] corner_s2 [4];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) corner_s2[i] <= corner_nx[i];
		end
	end

	// ---------------- s3: box size, bottom middle ----------------
	logic signed [COORD_W:0] wid, hgt;
	logic [COORD_W:0]        usum;
	asp_t                    asp_nx;
	asp_t                    asp_s3, asp_s4, asp_s5, asp_s6;
	logic [COORD_W-1:0]      u_s3, v_s3;

	assign wid  = $signed({1'b0, corner_s2[2]}) - $signed({1'b0, corner_s2[0]});
	assign hgt  = $signed({1'b0, corner_s2[3]}) - $signed({1'b0, corner_s2[1]});
	assign usum = {1'b0, corner_s2[0]} + {1'b0, corner_s2[2]};

	always_comb begin
		asp_nx.wid_mag = wid[COORD_W] ? COORD_W'(-wid) : COORD_W'(wid);
		asp_nx.hgt_mag = hgt[COORD_W] ? COORD_W'(-hgt) : COORD_W'(hgt);
		asp_nx.hzero   = hgt == '0;
		// aspect at or below zero
		asp_nx.neg     = (wid == '0) || (wid[COORD_W] != hgt[COORD_W]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			asp_s3 <= asp_nx;
			u_s3   <= usum[COORD_W:1];
			v_s3   <= corner_s2[3];
		end
	end

	// ---------------- s4: homography products ----------------
	logic signed [COORD_W:0] us, vs;
	logic signed [56:0]      hu0_s4, hu3_s4, hu6_s4, hv1_s4, hv4_s4, hv7_s4;

	assign us = $signed({1'b0, u_s3});
	assign vs = $signed({1'b0, v_s3});

	always_ff @(posedge clk) begin
		if (en) begin
			hu0_s4 <= h0 * us;
			hu3_s4 <= h3 * us;
			hu6_s4 <= h6 * us;
			hv1_s4 <= h1 * vs;
			hv4_s4 <= h4 * vs;
			hv7_s4 <= h7 * vs;
			asp_s4 <= asp_s3;
		end
	end

	// ---------------- s5: row sums for both points ----------------
	// upper point row = lower point row - 256 * h(column v)
	logic signed [58:0] kx1, ky1, kw1, kx2, ky2, kw2;
	logic signed [58:0] prj_s5 [6];

	assign kx1 = 59'(h2) <<< 8;
	assign ky1 = 59'(h5) <<< 8;
	assign kw1 = 59'(h8) <<< 8;
	assign kx2 = (59'(h2) - 59'(h1)) <<< 8;
	assign ky2 = (59'(h5) - 59'(h4)) <<< 8;
	assign kw2 = (59'(h8) - 59'(h7)) <<< 8;

	always_ff @(posedge clk) begin
		if (en) begin
			prj_s5[0] <= 59'(hu0_s4) + 59'(hv1_s4) + kx1;
			prj_s5[1] <= 59'(hu3_s4) + 59'(hv4_s4) + ky1;
			prj_s5[2] <= 59'(hu6_s4) + 59'(hv7_s4) + kw1;
			prj_s5[3] <= 59'(hu0_s4) + 59'(hv1_s4) + kx2;
			prj_s5[4] <= 59'(hu3_s4) + 59'(hv4_s4) + ky2;
			prj_s5[5] <= 59'(hu6_s4) + 59'(hv7_s4) + kw2;
			asp_s5    <= asp_s4;
		end
	end

	// ---------------- s6: magnitudes and signs ----------------
	logic [57:0] mag_s6 [6];
	logic [5:0]  sgn_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 6; i++) begin
				mag_s6[i] <= prj_s5[i][58] ? 58'(-prj_s5[i]) : 58'(prj_s5[i]);
				sgn_s6[i] <= prj_s5[i][58];
			end
			asp_s6 <= asp_s5;
		end
	end

	// ---------------- projection and aspect dividers ----------------
	sideb_t            sb_nx;
	sideb_t            sb_q [DIV_QW];
	logic [DIV_QW-1:0] quot_b [4];
	logic [DIV_QW-1:0] quot_asp;

	for (genvar i = 0; i < 4; i++) begin : g_proj
		localparam int NI = (i < 2) ? i : i + 1;
		localparam int DI = (i < 2) ? 2 : 5;

		assign sb_nx.neg[i] = sgn_s6[NI] ^ sgn_s6[DI];
		// integer part of 32768 or more saturates
		assign sb_nx.sat[i] = 58'(mag_s6[NI] >> 15) >= mag_s6[DI];

		bgpl_div u_div (
			.clk     (clk),
			.en      (en),
			.divisor (DIV_DW'(mag_s6[DI])),
			.rem_in  (DIV_DW'(mag_s6[NI] >> 15)),
			.low_in  ({mag_s6[NI][14:0], 16'b0}),
			.quot    (quot_b[i])
		);
	end

	assign sb_nx.bad     = asp_s6.hzero || (mag_s6[2] == '0) || (mag_s6[5] == '0);
	assign sb_nx.asp_neg = asp_s6.neg;
	assign sb_nx.asp_big = asp_s6.wid_mag >= asp_s6.hgt_mag;

	bgpl_div u_div_asp (
		.clk     (clk),
		.en      (en),
		.divisor (DIV_DW'(asp_s6.hgt_mag)),
		.rem_in  (DIV_DW'(asp_s6.wid_mag)),
		.low_in  ('0),
		.quot    (quot_asp)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			sb_q[0] <= sb_nx;
			for (int k = 1; k < DIV_QW; k++) sb_q[k] <= sb_q[k-1];
		end
	end

	sideb_t                    sb_out;
	logic [15:0]               aq;
	logic [OFS_W-1:0]          ofs_nx;
	logic signed [WORLD_W-1:0] pt_nx [4];

	assign sb_out = sb_q[DIV_QW-1];
	assign aq     = quot_asp[DIV_QW-1 -: 16];

	always_comb begin
		if (sb_out.asp_neg) begin
			ofs_nx = OFS_HIGH;
		end else if (sb_out.asp_big) begin
			ofs_nx = OFS_LOW;
		end else if (aq <= ASPECT_HALF) begin
			ofs_nx = OFS_HIGH;
		end else begin
			ofs_nx = OFS_W'(OFS_BASE - {1'b0, aq, 1'b0});
		end
	end

	for (genvar i = 0; i < 4; i++) begin : g_pt
		logic signed [WORLD_W-1:0] qs;
		assign qs = $signed({1'b0, quot_b[i]});
		assign pt_nx[i] = sb_out.sat[i] ? (sb_out.neg[i] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) :
			(sb_out.neg[i] ? -qs : qs);
	end

	// ---------------- s7: projected points ----------------
	logic signed [WORLD_W-1:0] pt_s7 [4];
	logic [OFS_W-1:0]          ofs_s7;
	logic                      bad_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) pt_s7[i] <= pt_nx[i];
			ofs_s7 <= ofs_nx;
			bad_s7 <= sb_out.bad;
		end
	end

	// ---------------- s8: direction ----------------
	logic signed [WORLD_W:0]   dx_s8, dy_s8;
	logic signed [WORLD_W-1:0] p1x_s8, p1y_s8;
	logic [OFS_W-1:0]          ofs_s8;
	logic                      bad_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s8  <= 33'(pt_s7[2]) - 33'(pt_s7[0]);
			dy_s8  <= 33'(pt_s7[3]) - 33'(pt_s7[1]);
			p1x_s8 <= pt_s7[0];
			p1y_s8 <= pt_s7[1];
			ofs_s8 <= ofs_s7;
			bad_s8 <= bad_s7;
		end
	end

	// ---------------- s9: normalized magnitudes ----------------
	logic [WORLD_W:0] adx, ady, aor;
	logic [1:0]       sh;
	sidec_t           sc_s9, sc_s10, sc_s11;

	assign adx = dx_s8[WORLD_W] ? 33'(-dx_s8) : 33'(dx_s8);
	assign ady = dy_s8[WORLD_W] ? 33'(-dy_s8) : 33'(dy_s8);
	assign aor = adx | ady;

	// shift both until each is below 2^30
	always_comb begin
		if (aor[32]) begin
			sh = 2'd3;
		end else if (aor[31]) begin
			sh = 2'd2;
		end else if (aor[30]) begin
			sh = 2'd1;
		end else begin
			sh = 2'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sc_s9.ax       <= 30'(adx >> sh);
			sc_s9.ay       <= 30'(ady >> sh);
			sc_s9.base.p1x <= p1x_s8;
			sc_s9.base.p1y <= p1y_s8;
			sc_s9.base.ofs <= ofs_s8;
			sc_s9.base.sx  <= dx_s8[WORLD_W];
			sc_s9.base.sy  <= dy_s8[WORLD_W];
			sc_s9.base.bad <= bad_s8 || ((dx_s8 == '0) && (dy_s8 == '0));
		end
	end

	// ---------------- s10, s11: squared length ----------------
	logic [59:0]     sqx_s10, sqy_s10;
	logic [SQ_W-1:0] rad_s11;

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s10 <= sc_s9.ax * sc_s9.ax;
			sqy_s10 <= sc_s9.ay * sc_s9.ay;
			sc_s10  <= sc_s9;
			rad_s11 <= SQ_W'(sqx_s10) + SQ_W'(sqy_s10);
			sc_s11  <= sc_s10;
		end
	end

	// ---------------- length ----------------
	logic [SQ_RW-1:0] len;
	sidec_t           sc_q [SQ_RW];
	sidec_t           sc_out;

	bgpl_sqrt u_sqrt (
		.clk      (clk),
		.en       (en),
		.radicand (rad_s11),
		.root     (len)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			sc_q[0] <= sc_s11;
			for (int k = 1; k < SQ_RW; k++) sc_q[k] <= sc_q[k-1];
		end
	end

	assign sc_out = sc_q[SQ_RW-1];

	// ---------------- unit vector dividers ----------------
	logic [DIV_QW-1:0] quot_ux, quot_uy;
	sided_t            sd_q [DIV_QW];
	sided_t            sd_out;

	bgpl_div u_div_ux (
		.clk     (clk),
		.en      (en),
		.divisor (DIV_DW'(len)),
		.rem_in  (DIV_DW'(sc_out.ax >> 1)),
		.low_in  ({sc_out.ax[0], (DIV_QW - 1)'(0)}),
		.quot    (quot_ux)
	);

	bgpl_div u_div_uy (
		.clk     (clk),
		.en      (en),
		.divisor (DIV_DW'(len)),
		.rem_in  (DIV_DW'(sc_out.ay >> 1)),
		.low_in  ({sc_out.ay[0], (DIV_QW - 1)'(0)}),
		.quot    (quot_uy)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			sd_q[0] <= sc_out.base;
			for (int k = 1; k < DIV_QW; k++) sd_q[k] <= sd_q[k-1];
		end
	end

	assign sd_out = sd_q[DIV_QW-1];

	// ---------------- s12, s13: move along the unit vector ----------------
	logic [UNIT_W-1:0] ux_s12, uy_s12;
	sided_t            sd_s12, sd_s13;
	logic [33:0]       mvx_s13, mvy_s13;

	always_ff @(posedge clk) begin
		if (en) begin
			ux_s12  <= quot_ux[DIV_QW-1 -: UNIT_W];
			uy_s12  <= quot_uy[DIV_QW-1 -: UNIT_W];
			sd_s12  <= sd_out;
			mvx_s13 <= sd_s12.ofs * ux_s12;
			mvy_s13 <= sd_s12.ofs * uy_s12;
			sd_s13  <= sd_s12;
		end
	end

	logic [17:0]        mx, my;
	logic signed [33:0] smx, smy, sumx, sumy;

	assign mx   = mvx_s13[33:16];
	assign my   = mvy_s13[33:16];
	assign smx  = $signed(34'(mx));
	assign smy  = $signed(34'(my));
	assign sumx = 34'(sd_s13.p1x) + (sd_s13.sx ? -smx : smx);
	assign sumy = 34'(sd_s13.p1y) + (sd_s13.sy ? -smy : smy);

	always_comb begin
		res_nx.inv = sd_s13.bad;
		res_nx.wx  = sd_s13.bad ? '0 : sat32(sumx);
		res_nx.wy  = sd_s13.bad ? '0 : sat32(sumy);
	end

	// ---------------- output register with skid ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			sp_vld_q  <= 1'b0;
		end else if (!out_vld_q || result.ready) begin
			if (sp_vld_q) begin
				out_vld_q <= 1'b1;
				sp_vld_q  <= 1'b0;
			end else begin
				out_vld_q <= push;
			end
		end else if (push) begin
			sp_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || result.ready) begin
			out_q <= sp_vld_q ? sp_q : res_nx;
		end else if (push) begin
			sp_q <= res_nx;
		end
	end

	assign result.valid   = out_vld_q;
	assign result.world_x = out_q.wx;
	assign result.world_y = out_q.wy;
	assign result.invalid = out_q.inv;

	// ---------------- assertions ----------------
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		sp_vld_q |-> out_vld_q)
		else $error("skid entry held without an output entry");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !result.ready && push) |=> !box.ready)
		else $error("input still ready after a result was parked");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.invalid) |-> (result.world_x == '0 && result.world_y == '0))
		else $error("invalid result carries a nonzero position");

endmodule
